@@ rtl/core/assert_macros.svh @@
// assertion macros used by the maze carver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define RWMC_ASSERT_HOLDS(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("assertion failed");
`define RWMC_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RWMC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RWMC_ASSERT_HOLDS(lbl, ck, rn, prop)
`define RWMC_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define RWMC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

@@ rtl/core/rwmc_pkg.sv @@
// package: commands, directions, sizes and grid port types of the maze carver
`timescale 1ns / 1ps

package rwmc_pkg;

  localparam int CELL_ROWS_DEF = 10;
  localparam int CELL_COLS_DEF = 20;

  // cell coordinates, enough for up to 32 cells per side
  localparam int CRD_W = 5;

  localparam logic [1:0] CMD_WALK    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic             clear;
    logic             carve;
    logic             horiz;
    logic [CRD_W-1:0] cell_col;
    logic [CRD_W-1:0] cell_row;
    logic [CRD_W-1:0] wall_col;
    logic [CRD_W-1:0] wall_row;
  } grid_wr_t;

  typedef struct packed {
    logic             map_rd;
    logic [CRD_W-1:0] cell_col;
    logic [CRD_W-1:0] cell_row;
    logic [5:0]       map_x;
    logic [4:0]       map_y;
  } grid_rd_t;

endpackage

@@ rtl/core/rwmc_grid.sv @@
// maze storage: visited cells, horizontal and vertical passages
`timescale 1ns / 1ps

module rwmc_grid
  import rwmc_pkg::*;
#(
  parameter int CELL_ROWS = CELL_ROWS_DEF,
  parameter int CELL_COLS = CELL_COLS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  grid_wr_t wr,
  input  grid_rd_t rd,
  output logic     rd_bit
);

  localparam int CXW   = $clog2(CELL_COLS);
  localparam int CYW   = $clog2(CELL_ROWS);
  localparam int MAP_W = 2 * CELL_COLS + 1;
  localparam int MAP_H = 2 * CELL_ROWS + 1;

  logic [CELL_COLS-1:0] visited_r [CELL_ROWS];
  logic [CELL_COLS-2:0] hwall_r   [CELL_ROWS];
  logic [CELL_COLS-1:0] vwall_r   [CELL_ROWS-1];

  logic [CRD_W-1:0] hx;
  logic [CRD_W-1:0] hy;
  logic [CRD_W-1:0] hx_m1;
  logic [CRD_W-1:0] hy_m1;
  logic [CRD_W-1:0] vis_col;
  logic [CRD_W-1:0] vis_row;
  logic             vis_bit;
  logic             in_map;
  logic             map_bit;

  always_ff @(posedge clk) begin
    if (!rst_n || wr.clear) begin
      for (int i = 0; i < CELL_ROWS; i++) begin
        visited_r[i] <= CELL_COLS'(i == 0);
        hwall_r[i]   <= '0;
      end
      for (int i = 0; i < CELL_ROWS - 1; i++) begin
        vwall_r[i] <= '0;
      end
    end else if (wr.carve) begin
      visited_r[wr.cell_row[CYW-1:0]][wr.cell_col[CXW-1:0]] <= 1'b1;
      if (wr.horiz) begin
        hwall_r[wr.wall_row[CYW-1:0]][wr.wall_col[CXW-1:0]] <= 1'b1;
      end else begin
        vwall_r[wr.wall_row[CYW-1:0]][wr.wall_col[CXW-1:0]] <= 1'b1;
      end
    end
  end

  // map coordinates to cell units
  assign hx      = rd.map_x[5:1];
  assign hy      = {1'b0, rd.map_y[4:1]};
  assign hx_m1   = hx - 1'b1;
  assign hy_m1   = hy - 1'b1;
  assign vis_col = rd.map_rd ? hx : rd.cell_col;
  assign vis_row = rd.map_rd ? hy : rd.cell_row;
  assign vis_bit = visited_r[vis_row[CYW-1:0]][vis_col[CXW-1:0]];
  assign in_map  = (rd.map_x < 6'(MAP_W)) && ({1'b0, rd.map_y} < 6'(MAP_H));

  always_comb begin
    map_bit = 1'b0;
    unique case ({rd.map_x[0], rd.map_y[0]})
      2'b11: map_bit = vis_bit;
      2'b01: begin
        if (hx != '0 && {1'b0, hx} < 6'(CELL_COLS)) begin
          map_bit = hwall_r[hy[CYW-1:0]][hx_m1[CXW-1:0]];
        end
      end
      2'b10: begin
        if (hy != '0 && {1'b0, hy} < 6'(CELL_ROWS)) begin
          map_bit = vwall_r[hy_m1[CYW-1:0]][hx[CXW-1:0]];
        end
      end
      default: map_bit = 1'b0;
    endcase
  end

  assign rd_bit = rd.map_rd ? (in_map & map_bit) : vis_bit;

endmodule

@@ rtl/core/random_walk_maze_carver.sv @@
// top level of the random walk maze carver
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Random walk maze carver. Every transfer on the input channel (walk step, restart, map read or
// other command) gives exactly one result transfer. An item is taken into an input register,
// worked against the maze held in flip-flops, and its result is kept in an output register:
// one item per cycle sustained while the result side does not stall. Restart clears the
// whole maze.
module random_walk_maze_carver
  import rwmc_pkg::*;
#(
  parameter int CELL_ROWS = CELL_ROWS_DEF,
  parameter int CELL_COLS = CELL_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [1:0] in_direction,
  input  logic [5:0] in_read_x,
  input  logic [4:0] in_read_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_pos_x,
  output logic [4:0] out_pos_y,
  output logic       out_carved,
  output logic [5:0] out_wall_x,
  output logic [4:0] out_wall_y,
  output logic [7:0] out_cells_left,
  output logic       out_done_res,
  output logic       out_cell_open
);

  localparam int CELLS = CELL_ROWS * CELL_COLS;
  localparam int CNT_W = $clog2(CELLS);

  logic             s1_valid_r, s1_valid_nxt;
  logic [1:0]       s1_cmd_r;
  logic [1:0]       s1_dir_r;
  logic [5:0]       s1_rx_r;
  logic [4:0]       s1_ry_r;

  logic [CRD_W-1:0] wx_r, wx_nxt;
  logic [CRD_W-1:0] wy_r, wy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [5:0]       pos_x_r;
  logic [4:0]       pos_y_r;
  logic             carved_r;
  logic [5:0]       wall_x_r;
  logic [4:0]       wall_y_r;
  logic [7:0]       cells_left_r;
  logic             done_r;
  logic             cell_open_r;

  logic             adv;
  logic             in_xfer;
  logic             walk;
  logic             in_range;
  logic             horiz;
  logic             carve;
  logic [CRD_W-1:0] tx;
  logic [CRD_W-1:0] ty;
  logic [CRD_W-1:0] wcol;
  logic [CRD_W-1:0] wrow;
  logic [5:0]       wall_x_nxt;
  logic [4:0]       wall_y_nxt;
  logic             rd_bit;
  grid_wr_t         gwr;
  grid_rd_t         grd;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;
  assign walk     = adv && (s1_cmd_r == CMD_WALK) && (cnt_r != '0);

  always_comb begin
    tx       = wx_r;
    ty       = wy_r;
    in_range = 1'b0;
    horiz    = 1'b1;
    wcol     = wx_r;
    wrow     = wy_r;
    unique case (s1_dir_r)
      DIR_RIGHT: begin
        tx       = wx_r + 1'b1;
        in_range = ({1'b0, wx_r} + 6'd1) < 6'(CELL_COLS);
      end
      DIR_LEFT: begin
        tx       = wx_r - 1'b1;
        in_range = (wx_r != '0);
        wcol     = tx;
      end
      DIR_DOWN: begin
        ty       = wy_r + 1'b1;
        in_range = ({1'b0, wy_r} + 6'd1) < 6'(CELL_ROWS);
        horiz    = 1'b0;
      end
      DIR_UP: begin
        ty       = wy_r - 1'b1;
        in_range = (wy_r != '0);
        horiz    = 1'b0;
        wrow     = ty;
      end
      default: in_range = 1'b0;
    endcase
  end

  assign grd.map_rd   = (s1_cmd_r == CMD_READ);
  assign grd.cell_col = tx;
  assign grd.cell_row = ty;
  assign grd.map_x    = s1_rx_r;
  assign grd.map_y    = s1_ry_r;

  assign carve = walk && in_range && !rd_bit;

  assign gwr.clear    = adv && (s1_cmd_r == CMD_RESTART);
  assign gwr.carve    = carve;
  assign gwr.horiz    = horiz;
  assign gwr.cell_col = tx;
  assign gwr.cell_row = ty;
  assign gwr.wall_col = wcol;
  assign gwr.wall_row = wrow;

  rwmc_grid #(
    .CELL_ROWS(CELL_ROWS),
    .CELL_COLS(CELL_COLS)
  ) u_grid (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (gwr),
    .rd     (grd),
    .rd_bit (rd_bit)
  );

  // wall position in map coordinates
  always_comb begin
    wall_x_nxt = '0;
    wall_y_nxt = '0;
    if (carve) begin
      if (horiz) begin
        wall_x_nxt = 6'({1'b0, wx_r} + {1'b0, tx} + 6'd1);
        wall_y_nxt = 5'({wy_r, 1'b1});
      end else begin
        wall_x_nxt = {wx_r, 1'b1};
        wall_y_nxt = 5'({1'b0, wy_r} + {1'b0, ty} + 6'd1);
      end
    end
  end

  always_comb begin
    wx_nxt  = wx_r;
    wy_nxt  = wy_r;
    cnt_nxt = cnt_r;
    if (gwr.clear) begin
      wx_nxt  = '0;
      wy_nxt  = '0;
      cnt_nxt = CNT_W'(CELLS - 1);
    end else if (walk && in_range) begin
      wx_nxt = tx;
      wy_nxt = ty;
      if (carve) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wx_r        <= '0;
      wy_r        <= '0;
      cnt_r       <= CNT_W'(CELLS - 1);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      wx_r        <= wx_nxt;
      wy_r        <= wy_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= in_command;
      s1_dir_r <= in_direction;
      s1_rx_r  <= in_read_x;
      s1_ry_r  <= in_read_y;
    end
    if (adv) begin
      pos_x_r      <= {wx_nxt, 1'b1};
      pos_y_r      <= 5'({wy_nxt, 1'b1});
      carved_r     <= carve;
      wall_x_r     <= wall_x_nxt;
      wall_y_r     <= wall_y_nxt;
      cells_left_r <= 8'(cnt_nxt);
      done_r       <= (cnt_nxt == '0);
      cell_open_r  <= grd.map_rd & rd_bit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x      = pos_x_r;
  assign out_pos_y      = pos_y_r;
  assign out_carved     = carved_r;
  assign out_wall_x     = wall_x_r;
  assign out_wall_y     = wall_y_r;
  assign out_cells_left = cells_left_r;
  assign out_done_res   = done_r;
  assign out_cell_open  = cell_open_r;

  `RWMC_ASSERT_HOLDS(a_walker_inside, clk, rst_n,
    ({1'b0, wx_r} < 6'(CELL_COLS)) && ({1'b0, wy_r} < 6'(CELL_ROWS)))
  `RWMC_ASSERT_NEXT(a_carve_counts, clk, rst_n, carve, cnt_r == CNT_W'($past(cnt_r) - 1'b1))
  `RWMC_ASSERT_IMPL(a_done_no_carve, clk, rst_n, cnt_r == '0, !carve)

endmodule

@@ verif/random_walk_maze_carver_checker.sv @@
`timescale 1ns / 1ps
// checker for the maze carver: predicts every result from the input transfers and compares

module random_walk_maze_carver_checker
  import rwmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [1:0] in_direction,
  input  logic [5:0] in_read_x,
  input  logic [4:0] in_read_y,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [5:0] out_pos_x,
  input  logic [4:0] out_pos_y,
  input  logic       out_carved,
  input  logic [5:0] out_wall_x,
  input  logic [4:0] out_wall_y,
  input  logic [7:0] out_cells_left,
  input  logic       out_done_res,
  input  logic       out_cell_open,
  output int         fail_count,
  output int         pending
);

  localparam int MAP_H = 2 * CELL_ROWS_DEF + 1;
  localparam int MAP_W = 2 * CELL_COLS_DEF + 1;

  typedef struct packed {
    logic [5:0] pos_x;
    logic [4:0] pos_y;
    logic       carved;
    logic [5:0] wall_x;
    logic [4:0] wall_y;
    logic [7:0] cells_left;
    logic       done_res;
    logic       cell_open;
  } maze_result_t;

  logic [MAP_W-1:0] maze_bits [MAP_H];
  int               walker_col;
  int               walker_row;
  int               cells_to_visit;
  int               mismatches = 0;
  maze_result_t     maze_results_q [$];

  function automatic void clear_maze();
    for (int r = 0; r < MAP_H; r++) maze_bits[r] = '0;
    maze_bits[1][1] = 1'b1;
    walker_col      = 1;
    walker_row      = 1;
    cells_to_visit  = CELL_ROWS_DEF * CELL_COLS_DEF - 1;
  endfunction

  function automatic maze_result_t carve_step(logic [1:0] cmd, logic [1:0] dir,
                                              logic [5:0] rx, logic [4:0] ry);
    maze_result_t res;
    int           nx;
    int           ny;
    int           wx;
    int           wy;
    res = '0;
    nx  = walker_col;
    ny  = walker_row;
    case (cmd)
      CMD_WALK: begin
        if (cells_to_visit != 0) begin
          case (dir)
            DIR_RIGHT: nx = walker_col + 2;
            DIR_LEFT:  nx = walker_col - 2;
            DIR_DOWN:  ny = walker_row + 2;
            DIR_UP:    ny = walker_row - 2;
            default: ;
          endcase
          if (nx >= 1 && nx <= MAP_W - 2 && ny >= 1 && ny <= MAP_H - 2) begin
            if (!maze_bits[ny][nx]) begin
              wx = (walker_col + nx) / 2;
              wy = (walker_row + ny) / 2;
              maze_bits[wy][wx] = 1'b1;
              maze_bits[ny][nx] = 1'b1;
              cells_to_visit--;
              res.carved = 1'b1;
              res.wall_x = 6'(wx);
              res.wall_y = 5'(wy);
            end
            walker_col = nx;
            walker_row = ny;
          end
        end
      end
      CMD_RESTART: clear_maze();
      CMD_READ: begin
        if (rx < MAP_W && ry < MAP_H) res.cell_open = maze_bits[ry][rx];
      end
      // remaining code leaves the state alone
      default: ;
    endcase
    res.pos_x      = 6'(walker_col);
    res.pos_y      = 5'(walker_row);
    res.cells_left = 8'(cells_to_visit);
    res.done_res   = (cells_to_visit == 0);
    return res;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    maze_result_t want;
    if (!rst_n) begin
      clear_maze();
      maze_results_q.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (maze_results_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual pos %0d,%0d",
                   $time, out_pos_x, out_pos_y);
          mismatches++;
        end else begin
          want = maze_results_q.pop_front();
          check_field("pos_x", 8'(want.pos_x), 8'(out_pos_x));
          check_field("pos_y", 8'(want.pos_y), 8'(out_pos_y));
          check_field("carved", 8'(want.carved), 8'(out_carved));
          check_field("wall_x", 8'(want.wall_x), 8'(out_wall_x));
          check_field("wall_y", 8'(want.wall_y), 8'(out_wall_y));
          check_field("cells_left", want.cells_left, out_cells_left);
          check_field("done_res", 8'(want.done_res), 8'(out_done_res));
          check_field("cell_open", 8'(want.cell_open), 8'(out_cell_open));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        maze_results_q.push_back(carve_step(in_command, in_direction, in_read_x, in_read_y));
    end
    fail_count <= mismatches;
    pending    <= maze_results_q.size();
  end

endmodule

@@ verif/random_walk_maze_carver_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the maze carver: clock, reset, stimulus, flow control and verdict

module random_walk_maze_carver_tb
  import rwmc_pkg::*;
();

  localparam logic [1:0] CMD_IDLE  = 2'd3;
  localparam int         LIMIT     = 200000;
  localparam int         HOLD_AT   = 300;
  localparam int         HOLD_LEN  = 80;
  localparam int         RAND_ITEMS = 220;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_command;
  logic [1:0] in_direction;
  logic [5:0] in_read_x;
  logic [4:0] in_read_y;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] out_pos_x;
  logic [4:0] out_pos_y;
  logic       out_carved;
  logic [5:0] out_wall_x;
  logic [4:0] out_wall_y;
  logic [7:0] out_cells_left;
  logic       out_done_res;
  logic       out_cell_open;

  int fail_count;
  int pending;
  int cycles = 0;
  int calm_left = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  random_walk_maze_carver dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_direction  (in_direction),
    .in_read_x     (in_read_x),
    .in_read_y     (in_read_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_carved    (out_carved),
    .out_wall_x    (out_wall_x),
    .out_wall_y    (out_wall_y),
    .out_cells_left(out_cells_left),
    .out_done_res  (out_done_res),
    .out_cell_open (out_cell_open)
  );

  random_walk_maze_carver_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_direction  (in_direction),
    .in_read_x     (in_read_x),
    .in_read_y     (in_read_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_carved    (out_carved),
    .out_wall_x    (out_wall_x),
    .out_wall_y    (out_wall_y),
    .out_cells_left(out_cells_left),
    .out_done_res  (out_done_res),
    .out_cell_open (out_cell_open),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("random_walk_maze_carver_tb failed");
      $finish;
    end
  end

  // result side flow control, with one long hold that backs up the block
  int stall_cycles = 0;
  int stall_left = 0;
  int open_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycles++;
      if (stall_cycles == HOLD_AT) hold_left = HOLD_LEN;
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (open_left > 0) begin
        open_left--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        open_left = $urandom_range(0, 30);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [1:0] dir, logic [5:0] rx, logic [4:0] ry);
    int gap;
    if (!quiet) begin
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else if ($urandom_range(0, 15) == 0) begin
        calm_left = $urandom_range(10, 40);
      end
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_direction <= dir;
    in_read_x    <= rx;
    in_read_y    <= ry;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic send_walk(logic [1:0] dir);
    send_item(CMD_WALK, dir, 6'($urandom), 5'($urandom));
  endtask

  task automatic send_read(logic [5:0] rx, logic [4:0] ry);
    send_item(CMD_READ, 2'($urandom), rx, ry);
  endtask

  task automatic send_any_read();
    if ($urandom_range(0, 1) == 0)
      send_read(6'($urandom_range(0, 40)), 5'($urandom_range(0, 20)));
    else
      send_read(6'($urandom), 5'($urandom));
  endtask

  task automatic send_noise(logic [1:0] cmd);
    send_item(cmd, 2'($urandom), 6'($urandom), 5'($urandom));
  endtask

  initial begin
    logic [1:0] row_dir;
    int         pick;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= CMD_WALK;
    in_direction <= DIR_RIGHT;
    in_read_x    <= '0;
    in_read_y    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // edges of the grid, reads inside and outside, every command
    send_walk(DIR_UP);
    send_walk(DIR_LEFT);
    send_read(6'd1, 5'd1);
    send_read(6'd0, 5'd0);
    send_read(6'd63, 5'd31);
    send_read(6'd40, 5'd20);
    send_read(6'd41, 5'd1);
    send_noise(CMD_IDLE);
    send_walk(DIR_RIGHT);
    send_read(6'd2, 5'd1);
    send_walk(DIR_LEFT);
    send_walk(DIR_DOWN);
    send_walk(DIR_UP);
    send_noise(CMD_RESTART);
    send_read(6'd2, 5'd1);
    send_read(6'd3, 5'd1);
    send_walk(DIR_DOWN);

    // serpentine sweep that visits every cell and finishes the maze
    send_noise(CMD_RESTART);
    for (int row = 0; row < CELL_ROWS_DEF; row++) begin
      row_dir = (row % 2 == 0) ? DIR_RIGHT : DIR_LEFT;
      for (int k = 0; k < CELL_COLS_DEF - 1; k++) begin
        if (row == CELL_ROWS_DEF - 1 && k == 0) send_walk(DIR_DOWN);
        send_walk(row_dir);
        if ($urandom_range(0, 5) == 0) send_any_read();
        if ($urandom_range(0, 19) == 0) send_noise(CMD_IDLE);
      end
      if ($urandom_range(0, 1) == 0) send_walk(row_dir);
      send_walk(DIR_DOWN);
    end

    // walks after the maze is done
    repeat (15) begin
      send_walk(2'($urandom));
      if ($urandom_range(0, 2) == 0) send_any_read();
    end

    send_noise(CMD_RESTART);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - 60) quiet <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 72) send_walk(2'($urandom));
      else if (pick < 90) send_any_read();
      else if (pick < 97) send_noise(CMD_IDLE);
      else send_noise(CMD_RESTART);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("random_walk_maze_carver_tb passed");
    else
      $display("random_walk_maze_carver_tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rwmc_pkg.sv
rtl/core/rwmc_grid.sv
rtl/core/random_walk_maze_carver.sv
verif/random_walk_maze_carver_checker.sv
verif/random_walk_maze_carver_tb.sv
